>>> hdl/sparse_point_set_engine_macros.svh
// ----------------------------------------------------------------------------
// sparse point set engine assertion macros
// shared wrappers for the concurrent checks on the top level ports
// ----------------------------------------------------------------------------
`ifndef SPARSE_POINT_SET_ENGINE_MACROS_SVH
`define SPARSE_POINT_SET_ENGINE_MACROS_SVH

// check on every clock edge outside reset
`define SPSE_ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every clock edge, reset included
`define SPSE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/spse_pkg.sv
// ----------------------------------------------------------------------------
// spse_pkg
// shared types, field widths and codes of the sparse point set engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spse_pkg;

  // default sizes of the stores
  localparam int NUM_POINTS_DEF  = 512;
  localparam int MAX_MEMBERS_DEF = 256;
  localparam int MAX_STONES_DEF  = 512;

  // request and result field widths
  localparam int CMD_W      = 3;
  localparam int POINT_W    = 9;
  localparam int INDEX_W    = 9;
  localparam int MCOUNT_W   = 9;
  localparam int SCOUNT_W   = 10;
  localparam int VALUE_W    = 9;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR       = 3'd0,
    CMD_APPEND      = 3'd1,
    CMD_INSERT      = 3'd2,
    CMD_ERASE       = 3'd3,
    CMD_READ_MEMBER = 3'd4,
    CMD_READ_STONE  = 3'd5
  } cmd_t;

  // controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_LOOKUP,
    ST_FIX,
    ST_CLEAR,
    ST_RESULT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic init_step;
    logic issue;
    logic clr_step;
    logic lookup;
    logic fix;
    logic finish;
  } ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic init_done;
    logic is_clear;
    logic is_lookup;
    logic clr_done;
    logic need_fix;
    logic out_free;
  } stat_t;

endpackage

>>> hdl/spse_ctrl.sv
// ----------------------------------------------------------------------------
// spse_ctrl
// sequencer of the sparse point set engine: one request at a time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  spse_pkg::stat_t  st,
  output spse_pkg::ctrl_t  ctrl
);

  spse_pkg::state_t state;
  spse_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spse_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ctrl       = '0;
    s_tready   = 1'b0;
    unique case (state)
      spse_pkg::ST_INIT: begin
        ctrl.init_step = 1'b1;
        if (st.init_done) begin
          state_next = spse_pkg::ST_IDLE;
        end
      end
      spse_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.load  = 1'b1;
          state_next = spse_pkg::ST_EXEC;
        end
      end
      spse_pkg::ST_EXEC: begin
        ctrl.issue = 1'b1;
        if (st.is_clear) begin
          state_next = spse_pkg::ST_CLEAR;
        end else if (st.is_lookup) begin
          state_next = spse_pkg::ST_LOOKUP;
        end else begin
          state_next = spse_pkg::ST_RESULT;
        end
      end
      spse_pkg::ST_LOOKUP: begin
        ctrl.lookup = 1'b1;
        if (st.need_fix) begin
          state_next = spse_pkg::ST_FIX;
        end else begin
          state_next = spse_pkg::ST_RESULT;
        end
      end
      spse_pkg::ST_FIX: begin
        ctrl.fix   = 1'b1;
        state_next = spse_pkg::ST_RESULT;
      end
      spse_pkg::ST_CLEAR: begin
        ctrl.clr_step = 1'b1;
        if (st.clr_done) begin
          state_next = spse_pkg::ST_RESULT;
        end
      end
      spse_pkg::ST_RESULT: begin
        if (st.out_free) begin
          ctrl.finish = 1'b1;
          state_next  = spse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spse_pkg::ST_INIT;
      end
    endcase
  end

endmodule

>>> hdl/spse_dp.sv
// ----------------------------------------------------------------------------
// spse_dp
// datapath: member list, slot map, stone list, counts and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spse_dp #(
  parameter int NUM_POINTS  = spse_pkg::NUM_POINTS_DEF,
  parameter int MAX_MEMBERS = spse_pkg::MAX_MEMBERS_DEF,
  parameter int MAX_STONES  = spse_pkg::MAX_STONES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  spse_pkg::ctrl_t                 ctrl,
  output spse_pkg::stat_t                 st,
  input  logic [spse_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [spse_pkg::CMD_W-1:0]      s_tuser,
  input  logic                            cfg_we,
  input  logic                            cfg_data,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [spse_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int POINT_W = spse_pkg::POINT_W;
  localparam int INDEX_W = spse_pkg::INDEX_W;
  localparam int PAW = $clog2(NUM_POINTS);
  localparam int MAW = $clog2(MAX_MEMBERS);
  localparam int SAW = $clog2(MAX_STONES);
  localparam int MCW = $clog2(MAX_MEMBERS + 1);
  localparam int SCW = $clog2(MAX_STONES + 1);
  localparam int PCW = $clog2(NUM_POINTS + 1);
  localparam int PXW = (PCW > POINT_W) ? PCW : POINT_W;
  localparam int MXW = (MCW > INDEX_W) ? MCW : INDEX_W;
  localparam int SXW = (SCW > INDEX_W) ? SCW : INDEX_W;

  // latched request
  logic [spse_pkg::CMD_W-1:0] cmd_q;
  logic [POINT_W-1:0]         point_q;
  logic [INDEX_W-1:0]         index_q;

  // counts, colour and walk counters
  logic [MCW-1:0] mtotal;
  logic [SCW-1:0] stotal;
  logic           color;
  logic [PAW-1:0] icnt;
  logic [MCW-1:0] ccnt;
  logic           pend;

  // result fields and deferred slot update
  logic                         chg;
  logic                         full;
  logic [spse_pkg::VALUE_W-1:0] rv;
  logic [POINT_W-1:0]           fix_point;
  logic [MCW-1:0]               fix_slot;

  // stores
  logic [POINT_W-1:0] member_mem [MAX_MEMBERS];
  logic [MCW-1:0]     slot_mem   [NUM_POINTS];
  logic [POINT_W-1:0] stone_mem  [MAX_STONES];
  logic [POINT_W-1:0] member_rd;
  logic [MCW-1:0]     slot_rd;
  logic [POINT_W-1:0] stone_rd;

  // memory port controls
  logic               mem_we, mem_re;
  logic [MAW-1:0]     mem_waddr, mem_raddr;
  logic [POINT_W-1:0] mem_wdata;
  logic               slot_we, slot_re;
  logic [PAW-1:0]     slot_waddr, slot_raddr;
  logic [MCW-1:0]     slot_wdata;
  logic               stone_we, stone_re;
  logic [SAW-1:0]     stone_waddr, stone_raddr;

  // request decode
  logic is_clear, is_append, is_insert, is_erase, is_rmember, is_rstone;
  logic on_board, rd_on_board;
  logic [PAW-1:0] pt_addr;
  logic m_full, s_full, m_rd_ok, s_rd_ok, clr_more, clr_done;
  logic insert_new, erase_hit, pos_in, do_move;
  logic [MCW-1:0] pos, last;

  assign is_clear   = (cmd_q == spse_pkg::CMD_CLEAR);
  assign is_append  = (cmd_q == spse_pkg::CMD_APPEND);
  assign is_insert  = (cmd_q == spse_pkg::CMD_INSERT);
  assign is_erase   = (cmd_q == spse_pkg::CMD_ERASE);
  assign is_rmember = (cmd_q == spse_pkg::CMD_READ_MEMBER);
  assign is_rstone  = (cmd_q == spse_pkg::CMD_READ_STONE);

  assign on_board    = PXW'(point_q) < PXW'(NUM_POINTS);
  assign rd_on_board = PXW'(member_rd) < PXW'(NUM_POINTS);
  assign pt_addr     = PAW'(point_q);
  assign m_full      = mtotal >= MCW'(MAX_MEMBERS);
  assign s_full      = stotal >= SCW'(MAX_STONES);
  assign m_rd_ok     = MXW'(index_q) < MXW'(mtotal);
  assign s_rd_ok     = SXW'(index_q) < SXW'(stotal);
  assign clr_more    = ccnt < mtotal;
  assign clr_done    = !clr_more && !pend;

  // lookup results, valid in the cycle after the reads were issued
  assign insert_new = is_insert && on_board && (slot_rd == '0);
  assign erase_hit  = is_erase && on_board && (slot_rd != '0);
  assign pos        = slot_rd - 1'b1;
  assign last       = mtotal - 1'b1;
  assign pos_in     = pos < mtotal;
  assign do_move    = pos_in && (pos < last);

  // status to the controller
  always_comb begin
    st.init_done = (icnt == PAW'(NUM_POINTS - 1));
    st.is_clear  = is_clear;
    st.is_lookup = is_insert || is_erase || is_rmember || is_rstone;
    st.clr_done  = clr_done;
    st.need_fix  = erase_hit && do_move && rd_on_board;
    st.out_free  = !m_tvalid || m_tready;
  end

  // member list ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = MAW'(mtotal);
    mem_wdata = point_q;
    if (ctrl.lookup && insert_new && !m_full) begin
      mem_we = 1'b1;
    end else if (ctrl.lookup && erase_hit && do_move) begin
      mem_we    = 1'b1;
      mem_waddr = MAW'(pos);
      mem_wdata = member_rd;
    end
    mem_re    = 1'b0;
    mem_raddr = MAW'(ccnt);
    if (ctrl.issue && is_erase) begin
      mem_re    = 1'b1;
      mem_raddr = MAW'(last);
    end else if (ctrl.issue && is_rmember) begin
      mem_re    = 1'b1;
      mem_raddr = MAW'(index_q);
    end else if (ctrl.clr_step && clr_more) begin
      mem_re = 1'b1;
    end
  end

  // slot map ports
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = pt_addr;
    slot_wdata = '0;
    if (ctrl.init_step) begin
      slot_we    = 1'b1;
      slot_waddr = icnt;
    end else if (ctrl.clr_step && pend && rd_on_board) begin
      slot_we    = 1'b1;
      slot_waddr = PAW'(member_rd);
    end else if (ctrl.lookup && insert_new && !m_full) begin
      slot_we    = 1'b1;
      slot_wdata = MCW'(mtotal + 1'b1);
    end else if (ctrl.lookup && erase_hit) begin
      slot_we = 1'b1;
    end else if (ctrl.fix) begin
      slot_we    = 1'b1;
      slot_waddr = PAW'(fix_point);
      slot_wdata = fix_slot;
    end
    slot_re    = ctrl.issue && (is_insert || is_erase);
    slot_raddr = pt_addr;
  end

  // stone list ports
  always_comb begin
    stone_we    = ctrl.issue && is_append && !s_full;
    stone_waddr = SAW'(stotal);
    stone_re    = ctrl.issue && is_rstone;
    stone_raddr = SAW'(index_q);
  end

  // memories with registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      member_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      member_rd <= member_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd <= slot_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stone_we) begin
      stone_mem[stone_waddr] <= point_q;
    end
    if (stone_re) begin
      stone_rd <= stone_mem[stone_raddr];
    end
  end

  // counts, colour, walk counters and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mtotal   <= '0;
      stotal   <= '0;
      color    <= 1'b0;
      icnt     <= '0;
      ccnt     <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        color <= cfg_data;
      end
      if (ctrl.init_step) begin
        icnt <= icnt + 1'b1;
      end
      if (ctrl.issue && is_clear) begin
        ccnt <= '0;
        pend <= 1'b0;
      end
      if (ctrl.issue && is_append && !s_full) begin
        stotal <= stotal + 1'b1;
      end
      if (ctrl.clr_step) begin
        pend <= clr_more;
        if (clr_more) begin
          ccnt <= ccnt + 1'b1;
        end
        if (clr_done) begin
          mtotal <= '0;
          stotal <= '0;
        end
      end
      if (ctrl.lookup && insert_new && !m_full) begin
        mtotal <= mtotal + 1'b1;
      end
      if (ctrl.lookup && erase_hit && pos_in) begin
        mtotal <= last;
      end
      if (ctrl.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request capture, result fields and output register
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q   <= s_tuser;
      point_q <= s_tdata[POINT_W-1:0];
      index_q <= s_tdata[POINT_W+INDEX_W-1:POINT_W];
      chg     <= 1'b0;
      full    <= 1'b0;
      rv      <= '0;
    end
    if (ctrl.issue && is_append) begin
      full <= s_full;
      chg  <= !s_full;
    end
    if (ctrl.clr_step && clr_done) begin
      chg <= 1'b1;
    end
    if (ctrl.lookup) begin
      fix_point <= member_rd;
      fix_slot  <= slot_rd;
      if (insert_new) begin
        full <= m_full;
        chg  <= !m_full;
      end
      if (erase_hit) begin
        chg <= 1'b1;
      end
      if (is_rmember && m_rd_ok) begin
        rv  <= member_rd;
        chg <= 1'b1;
      end
      if (is_rstone && s_rd_ok) begin
        rv  <= stone_rd;
        chg <= 1'b1;
      end
    end
    if (ctrl.finish) begin
      m_tdata <= {1'b0, color, rv, spse_pkg::SCOUNT_W'(stotal),
                  spse_pkg::MCOUNT_W'(mtotal), full, chg};
    end
  end

endmodule

>>> hdl/sparse_point_set_engine.sv
// ----------------------------------------------------------------------------
// sparse_point_set_engine
// sparse set of board points with swap-remove erase, plus a stone list
// ----------------------------------------------------------------------------
// usage: requests enter on the s_ channel (command in s_tuser, point and
// index in s_tdata); every request gives exactly one result on the m_
// channel with a changed flag, a full flag, both counts, the value read and
// the group colour. the colour register is written on the cfg_ channel,
// which is always ready; write it only while no request is in flight.
// one request is handled at a time, sequenced by a controller over
// single-port memories with registered reads:
//   append runs exec and result; insert and reads add a lookup state;
//   erase adds lookup and, when a member moves, fix (second slot map write);
//   clear walks the list (one member list read and one slot map write each).
// a result waits in the output register while m_tready is low; the next
// request is taken meanwhile and its result is held back until the
// register frees.
// reset: synchronous; afterwards the slot map is zeroed one entry per
// cycle, with s_tready low during that pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_point_set_engine #(
  parameter int NUM_POINTS  = spse_pkg::NUM_POINTS_DEF,
  parameter int MAX_MEMBERS = spse_pkg::MAX_MEMBERS_DEF,
  parameter int MAX_STONES  = spse_pkg::MAX_STONES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [spse_pkg::IN_DATA_W-1:0]  s_tdata,  // point, index, zero pad
  input  logic [spse_pkg::CMD_W-1:0]      s_tuser,  // cmd
  // result channel
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // changed, full_res, member_count, stone_count, read_value, color, zero pad
  output logic [spse_pkg::OUT_DATA_W-1:0] m_tdata,
  // colour register write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data
);

  spse_pkg::ctrl_t ctrl;
  spse_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  // sequencer
  spse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .ctrl     (ctrl)
  );

  // stores and result register
  spse_dp #(
    .NUM_POINTS  (NUM_POINTS),
    .MAX_MEMBERS (MAX_MEMBERS),
    .MAX_STONES  (MAX_STONES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .st       (st),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> hdl/spse_checker.sv
// ----------------------------------------------------------------------------
// spse_checker
// port-level checks of the sparse point set engine, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sparse_point_set_engine_macros.svh"

module spse_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [spse_pkg::OUT_DATA_W-1:0] m_tdata
);

  // a stalled result stays offered
  `SPSE_ASSERT_ON(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

  // a stalled result keeps its value
  `SPSE_ASSERT_ON(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")

  // one request at a time: no request taken right after another
  `SPSE_ASSERT_ON(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "back to back request taken")

  // reset leaves no result and starts the slot map pass
  `SPSE_ASSERT_ALWAYS(a_reset_quiet, rst |=> !s_tready && !m_tvalid, "not quiet after reset")

endmodule

bind sparse_point_set_engine spse_checker u_spse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
